// ===== design/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsd_pkg;

    localparam logic [2:0] KIND_DATA      = 3'd0;
    localparam logic [2:0] KIND_SEND_PONG = 3'd1;
    localparam logic [2:0] KIND_PONG_SEEN = 3'd2;
    localparam logic [2:0] KIND_CLOSE     = 3'd3;
    localparam logic [2:0] KIND_BAD_OP    = 3'd4;
    localparam logic [2:0] KIND_TOO_LONG  = 3'd5;
    localparam logic [2:0] KIND_EMPTY     = 3'd6;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [31:0] MAX_LEN_RESET = 32'h0004_0000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [6:0] {
        PH_HDR0    = 7'b0000001,
        PH_HDR1    = 7'b0000010,
        PH_EXT16   = 7'b0000100,
        PH_EXT64HI = 7'b0001000,
        PH_EXT64LO = 7'b0010000,
        PH_MASK    = 7'b0100000,
        PH_PAYLOAD = 7'b1000000
    } wsd_phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [3:0]  frame_opcode;
        logic        frame_last;
        logic        message_end;
        logic [31:0] message_length;
        logic [15:0] chunk_index;
    } wsd_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } wsd_qstat_t;

endpackage

// ===== design/websocket_frame_deframer.sv =====
// Top level of the WebSocket receive frame deframer.
// Usage:
//   s_tvalid/s_tready/s_tdata carry received socket bytes, one byte per beat.
//   The parser reads the two header bytes, any 16- or 64-bit extended length and
//   the mask key, then unmasks text, binary and continuation payload bytes.
//   m_tvalid/m_tready/m_tdata/m_tlast/m_tuser carry zero or one result per input
//   beat: tuser holds the kind, tlast the last byte, empty or control result of a frame.
//   cfg_valid/cfg_ready/cfg_data write the 64-bit-form length limit; cfg_ready
//   is always high. Write it only while no beat is in flight.
// Throughput: one byte per clock while the result queue is not full; the parser
//   settles each byte in combinational header and payload logic.
// A result is written into the queue, then into the output register that drives m_tvalid.
// Reset (rst_n low, asynchronous): parser waits for a first header byte, the
//   length limit returns to 262144 and the result queue empties.
// Stall: a four-entry queue and the output register absorb results while
//   m_tready is low; s_tready drops only when the queue is full.
// After a close frame, a bad opcode or a bad length every byte is accepted and
//   dropped until reset.
`timescale 1ns / 1ps

module websocket_frame_deframer
    import wsd_pkg::*;
#(
    parameter int CHUNK_BYTES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] data_byte, [11:8] frame_opcode, [12] message_end,
                                   // [44:13] message_length, [60:45] chunk_index
    output logic        m_tlast,
    output logic [7:0]  m_tuser,   // [2:0] kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic       accept;
    logic       rec_valid;
    wsd_rec_t   rec;
    wsd_rec_t   q_rdata;
    wsd_qstat_t q_stat;
    logic       q_pop;

    assign s_tready  = ~q_stat.full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid & s_tready;

    wsd_front #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (s_tdata),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_value (cfg_data),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    wsd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rec_valid),
        .wdata (rec),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    wsd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_rdata  (q_rdata),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== design/wsd_front.sv =====
// Front end: header parser, unmasking and result classification per received byte.
`timescale 1ns / 1ps

module wsd_front
    import wsd_pkg::*;
#(
    parameter int CHUNK_BYTES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_write,
    input  logic [31:0] cfg_value,
    output logic        rec_valid,
    output wsd_rec_t    rec
);

    localparam int CB_W = $clog2(CHUNK_BYTES);
    localparam logic [CB_W-1:0] CB_LAST = CB_W'(CHUNK_BYTES - 1);
    localparam logic [31:0] CHUNK_LEN = 32'(CHUNK_BYTES);

    wsd_phase_t  phase_reg, phase_next;
    logic        stopped_reg, stopped_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [31:0] plen_reg, plen_next;
    logic [1:0]  hcnt_reg, hcnt_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] msum_reg, msum_next;
    logic [15:0] chunk_reg, chunk_next;
    logic        chunked_reg, chunked_next;
    logic [CB_W-1:0] cbyte_reg, cbyte_next;
    logic [31:0] max_len_reg;

    always_comb
    begin
        logic [31:0] len_new;
        logic        len_done;
        logic        hd;
        logic        ctrl_end;
        logic        emit;
        logic        last;
        logic [7:0]  key_byte;
        logic [31:0] pos_inc;

        phase_next   = phase_reg;
        stopped_next = stopped_reg;
        fin_next     = fin_reg;
        opcode_next  = opcode_reg;
        masked_next  = masked_reg;
        plen_next    = plen_reg;
        hcnt_next    = hcnt_reg;
        key_next     = key_reg;
        pos_next     = pos_reg;
        msum_next    = msum_reg;
        chunk_next   = chunk_reg;
        chunked_next = chunked_reg;
        cbyte_next   = cbyte_reg;

        len_new  = plen_reg;
        len_done = 1'b0;
        hd       = 1'b0;
        ctrl_end = 1'b0;
        emit     = 1'b0;
        last     = 1'b0;
        key_byte = 8'd0;
        pos_inc  = pos_reg + 32'd1;

        rec.kind           = KIND_DATA;
        rec.data_byte      = 8'd0;
        rec.frame_opcode   = opcode_reg;
        rec.frame_last     = 1'b0;
        rec.message_end    = 1'b0;
        rec.message_length = 32'd0;
        rec.chunk_index    = 16'd0;

        unique case (phase_reg)
            PH_HDR0:
            begin
                fin_next    = rx_byte[7];
                opcode_next = rx_byte[3:0];
                phase_next  = PH_HDR1;
            end
            PH_HDR1:
            begin
                masked_next = rx_byte[7];
                hcnt_next   = 2'd0;
                plen_next   = 32'd0;
                if (rx_byte[6:0] == LEN_EXT16)
                begin
                    phase_next = PH_EXT16;
                end
                else if (rx_byte[6:0] == LEN_EXT64)
                begin
                    phase_next = PH_EXT64HI;
                end
                else
                begin
                    len_new  = {25'd0, rx_byte[6:0]};
                    len_done = 1'b1;
                end
            end
            PH_EXT16:
            begin
                len_new   = {16'd0, plen_reg[7:0], rx_byte};
                plen_next = len_new;
                hcnt_next = hcnt_reg + 2'd1;
                len_done  = (hcnt_reg == 2'd1);
            end
            PH_EXT64HI:
            begin
                plen_next = plen_reg | {24'd0, rx_byte};
                hcnt_next = hcnt_reg + 2'd1;
                if (hcnt_reg == 2'd3)
                begin
                    if (plen_next != 32'd0)
                    begin
                        stopped_next = 1'b1;
                        emit         = 1'b1;
                        rec.kind     = KIND_TOO_LONG;
                    end
                    else
                    begin
                        plen_next  = 32'd0;
                        hcnt_next  = 2'd0;
                        phase_next = PH_EXT64LO;
                    end
                end
            end
            PH_EXT64LO:
            begin
                len_new   = {plen_reg[23:0], rx_byte};
                plen_next = len_new;
                hcnt_next = hcnt_reg + 2'd1;
                if (hcnt_reg == 2'd3)
                begin
                    if (len_new > max_len_reg)
                    begin
                        stopped_next = 1'b1;
                        emit         = 1'b1;
                        rec.kind     = KIND_TOO_LONG;
                    end
                    else
                    begin
                        len_done = 1'b1;
                    end
                end
            end
            PH_MASK:
            begin
                key_next  = {key_reg[23:0], rx_byte};
                hcnt_next = hcnt_reg + 2'd1;
                if (hcnt_reg == 2'd3)
                begin
                    len_new = plen_reg;
                    hd      = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                last     = (pos_inc == plen_reg);
                pos_next = pos_inc;
                if (opcode_reg > OP_BIN)
                begin
                    ctrl_end = last;
                end
                else
                begin
                    unique case (pos_reg[1:0])
                        2'd0: key_byte = key_reg[31:24];
                        2'd1: key_byte = key_reg[23:16];
                        2'd2: key_byte = key_reg[15:8];
                        2'd3: key_byte = key_reg[7:0];
                    endcase
                    emit               = 1'b1;
                    rec.kind           = KIND_DATA;
                    rec.data_byte      = masked_reg ? (rx_byte ^ key_byte) : rx_byte;
                    rec.frame_last     = last;
                    rec.message_end    = last & fin_reg;
                    rec.message_length = (last & fin_reg) ? msum_reg : 32'd0;
                    rec.chunk_index    = chunked_reg ? chunk_reg : 16'd0;
                    if (chunked_reg && (last || cbyte_reg == CB_LAST))
                    begin
                        chunk_next = chunk_reg + 16'd1;
                    end
                    cbyte_next = (cbyte_reg == CB_LAST) ? '0 : cbyte_reg + CB_W'(1);
                    if (last)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
            end
        endcase

        if (len_done)
        begin
            plen_next = len_new;
            hcnt_next = 2'd0;
            if (masked_next)
            begin
                key_next   = 32'd0;
                phase_next = PH_MASK;
            end
            else
            begin
                hd = 1'b1;
            end
        end

        if (hd)
        begin
            chunked_next = (len_new > CHUNK_LEN) || (opcode_reg == OP_CONT);
            if (opcode_reg == OP_CONT)
            begin
                msum_next = msum_reg + len_new;
            end
            else if (opcode_reg == OP_TEXT || opcode_reg == OP_BIN)
            begin
                msum_next = len_new;
                if (chunked_next)
                begin
                    chunk_next = 16'd0;
                end
            end
            pos_next   = 32'd0;
            cbyte_next = '0;
            if (len_new == 32'd0)
            begin
                phase_next = PH_HDR0;
                if (opcode_reg <= OP_BIN)
                begin
                    emit               = 1'b1;
                    rec.kind           = KIND_EMPTY;
                    rec.frame_last     = 1'b1;
                    rec.message_end    = fin_reg;
                    rec.message_length = fin_reg ? msum_next : 32'd0;
                end
                else
                begin
                    ctrl_end = 1'b1;
                end
            end
            else
            begin
                phase_next = PH_PAYLOAD;
            end
        end

        if (ctrl_end)
        begin
            phase_next     = PH_HDR0;
            emit           = 1'b1;
            rec.frame_last = 1'b1;
            unique case (opcode_reg)
                OP_PING:  rec.kind = KIND_SEND_PONG;
                OP_PONG:  rec.kind = KIND_PONG_SEEN;
                OP_CLOSE: rec.kind = KIND_CLOSE;
                default:  rec.kind = KIND_BAD_OP;
            endcase
            if (rec.kind == KIND_CLOSE || rec.kind == KIND_BAD_OP)
            begin
                stopped_next = 1'b1;
            end
        end

        rec_valid = accept & ~stopped_reg & emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_write)
        begin
            max_len_reg <= cfg_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            stopped_reg <= 1'b0;
            fin_reg     <= 1'b0;
            opcode_reg  <= 4'd0;
            masked_reg  <= 1'b0;
            plen_reg    <= 32'd0;
            hcnt_reg    <= 2'd0;
            key_reg     <= 32'd0;
            pos_reg     <= 32'd0;
            msum_reg    <= 32'd0;
            chunk_reg   <= 16'd0;
            chunked_reg <= 1'b0;
            cbyte_reg   <= '0;
        end
        else if (accept && !stopped_reg)
        begin
            phase_reg   <= phase_next;
            stopped_reg <= stopped_next;
            fin_reg     <= fin_next;
            opcode_reg  <= opcode_next;
            masked_reg  <= masked_next;
            plen_reg    <= plen_next;
            hcnt_reg    <= hcnt_next;
            key_reg     <= key_next;
            pos_reg     <= pos_next;
            msum_reg    <= msum_next;
            chunk_reg   <= chunk_next;
            chunked_reg <= chunked_next;
            cbyte_reg   <= cbyte_next;
        end
    end

endmodule

// ===== design/wsd_queue.sv =====
// Short result queue between the parser and the output stage.
`timescale 1ns / 1ps

module wsd_queue
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  wsd_rec_t   wdata,
    input  logic       pop,
    output wsd_rec_t   rdata,
    output wsd_qstat_t stat
);

    wsd_rec_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rdata      = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next  = pop ? rptr_reg + QPTR_W'(1) : rptr_reg;
        count_next = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/wsd_back.sv =====
// Back end: output register that drives the result stream.
`timescale 1ns / 1ps

module wsd_back
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  wsd_rec_t    q_rdata,
    input  wsd_qstat_t  q_stat,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic        m_tlast,
    output logic [7:0]  m_tuser
);

    logic     valid_reg, valid_next;
    wsd_rec_t out_reg;

    assign q_pop = ~q_stat.empty & (~valid_reg | m_tready);

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg <= q_rdata;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = out_reg.frame_last;
    assign m_tuser  = {5'd0, out_reg.kind};
    assign m_tdata  = {3'd0, out_reg.chunk_index, out_reg.message_length,
                       out_reg.message_end, out_reg.frame_opcode, out_reg.data_byte};

endmodule

// ===== test/wsd_stream_checker.sv =====
// Checker for the WebSocket deframer: predicts each result from the accepted bytes and compares.
`timescale 1ns / 1ps

module wsd_stream_checker
    import wsd_pkg::*;
#(
    parameter int CHUNK_BYTES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,
    input  logic [7:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending_count,
    output int          results_checked,
    output logic [7:0]  kinds_seen
);

    wsd_rec_t    parsed_results[$];

    wsd_phase_t  rx_phase;
    logic        hdr_fin;
    logic [3:0]  hdr_opcode;
    logic        hdr_masked;
    logic [31:0] frame_len;
    int unsigned len_bytes;
    logic [31:0] mask_word;
    logic [31:0] payload_idx;
    logic [31:0] msg_total;
    logic [15:0] chunk_num;
    logic        chunk_on;
    logic        halted;
    logic [31:0] len_limit;

    int          mismatches;
    int          checked;
    logic [7:0]  seen;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 50)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic push_result(input logic [2:0] kind, input logic [7:0] dbyte,
                               input logic last, input logic mend,
                               input logic [31:0] mlen, input logic [15:0] chunk);
        wsd_rec_t rec;
        rec.kind           = kind;
        rec.data_byte      = dbyte;
        rec.frame_opcode   = hdr_opcode;
        rec.frame_last     = last;
        rec.message_end    = mend;
        rec.message_length = mlen;
        rec.chunk_index    = chunk;
        parsed_results.push_back(rec);
    endtask

    task automatic end_control_frame();
        rx_phase = PH_HDR0;
        case (hdr_opcode)
            OP_PING: push_result(KIND_SEND_PONG, 8'h00, 1'b1, 1'b0, 32'd0, 16'd0);
            OP_PONG: push_result(KIND_PONG_SEEN, 8'h00, 1'b1, 1'b0, 32'd0, 16'd0);
            OP_CLOSE:
            begin
                halted = 1'b1;
                push_result(KIND_CLOSE, 8'h00, 1'b1, 1'b0, 32'd0, 16'd0);
            end
            default:
            begin
                halted = 1'b1;
                push_result(KIND_BAD_OP, 8'h00, 1'b1, 1'b0, 32'd0, 16'd0);
            end
        endcase
    endtask

    task automatic header_complete();
        chunk_on = (frame_len > CHUNK_BYTES) || (hdr_opcode == OP_CONT);
        if (hdr_opcode == OP_CONT)
            msg_total = msg_total + frame_len;
        else if (hdr_opcode == OP_TEXT || hdr_opcode == OP_BIN)
        begin
            msg_total = frame_len;
            if (chunk_on)
                chunk_num = 16'd0;
        end
        payload_idx = 32'd0;
        if (frame_len == 32'd0)
        begin
            rx_phase = PH_HDR0;
            if (hdr_opcode <= OP_BIN)
                push_result(KIND_EMPTY, 8'h00, 1'b1, hdr_fin,
                            hdr_fin ? msg_total : 32'd0, 16'd0);
            else
                end_control_frame();
        end
        else
            rx_phase = PH_PAYLOAD;
    endtask

    task automatic length_complete();
        len_bytes = 0;
        if (hdr_masked)
        begin
            mask_word = 32'd0;
            rx_phase  = PH_MASK;
        end
        else
            header_complete();
    endtask

    task automatic length_rejected();
        halted = 1'b1;
        push_result(KIND_TOO_LONG, 8'h00, 1'b0, 1'b0, 32'd0, 16'd0);
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        logic [31:0] next_idx;
        logic        last;
        logic [7:0]  d;
        logic [7:0]  key_byte;
        logic [15:0] chunk;
        logic        mend;
        if (halted)
            return;
        case (rx_phase)
            PH_HDR0:
            begin
                hdr_fin    = b[7];
                hdr_opcode = b[3:0];
                rx_phase   = PH_HDR1;
            end
            PH_HDR1:
            begin
                hdr_masked = b[7];
                len_bytes  = 0;
                frame_len  = 32'd0;
                if (b[6:0] == LEN_EXT16)
                    rx_phase = PH_EXT16;
                else if (b[6:0] == LEN_EXT64)
                    rx_phase = PH_EXT64HI;
                else
                begin
                    frame_len = {25'd0, b[6:0]};
                    length_complete();
                end
            end
            PH_EXT16:
            begin
                frame_len = {16'd0, frame_len[7:0], b};
                len_bytes++;
                if (len_bytes >= 2)
                    length_complete();
            end
            PH_EXT64HI:
            begin
                frame_len = frame_len | {24'd0, b};
                len_bytes++;
                if (len_bytes >= 4)
                begin
                    if (frame_len != 32'd0)
                        length_rejected();
                    else
                    begin
                        len_bytes = 0;
                        rx_phase  = PH_EXT64LO;
                    end
                end
            end
            PH_EXT64LO:
            begin
                frame_len = {frame_len[23:0], b};
                len_bytes++;
                if (len_bytes >= 4)
                begin
                    if (frame_len > len_limit)
                        length_rejected();
                    else
                        length_complete();
                end
            end
            PH_MASK:
            begin
                mask_word = {mask_word[23:0], b};
                len_bytes++;
                if (len_bytes >= 4)
                    header_complete();
            end
            PH_PAYLOAD:
            begin
                next_idx    = payload_idx + 32'd1;
                last        = (next_idx >= frame_len);
                key_byte    = 8'(mask_word >> (24 - 8 * int'(payload_idx[1:0])));
                payload_idx = next_idx;
                if (hdr_opcode > OP_BIN)
                begin
                    if (last)
                        end_control_frame();
                end
                else
                begin
                    d     = hdr_masked ? (b ^ key_byte) : b;
                    chunk = chunk_on ? chunk_num : 16'd0;
                    mend  = last && hdr_fin;
                    if (chunk_on && (last || (next_idx % CHUNK_BYTES) == 0))
                        chunk_num = chunk_num + 16'd1;
                    if (last)
                        rx_phase = PH_HDR0;
                    push_result(KIND_DATA, d, last, mend, mend ? msg_total : 32'd0, chunk);
                end
            end
            default: rx_phase = PH_HDR0;
        endcase
    endtask

    task automatic check_result();
        wsd_rec_t   want;
        logic [2:0] got_kind;
        got_kind       = m_tuser[2:0];
        seen[got_kind] = 1'b1;
        if (parsed_results.size() == 0)
            report_mismatch("result with nothing pending, kind", got_kind, 64'd0);
        else
        begin
            want = parsed_results.pop_front();
            checked++;
            if (got_kind != want.kind)
                report_mismatch("kind", got_kind, want.kind);
            if (m_tdata[7:0] != want.data_byte)
                report_mismatch("data_byte", m_tdata[7:0], want.data_byte);
            if (m_tdata[11:8] != want.frame_opcode)
                report_mismatch("frame_opcode", m_tdata[11:8], want.frame_opcode);
            if (m_tlast != want.frame_last)
                report_mismatch("frame_last", m_tlast, want.frame_last);
            if (m_tdata[12] != want.message_end)
                report_mismatch("message_end", m_tdata[12], want.message_end);
            if (m_tdata[44:13] != want.message_length)
                report_mismatch("message_length", m_tdata[44:13], want.message_length);
            if (m_tdata[60:45] != want.chunk_index)
                report_mismatch("chunk_index", m_tdata[60:45], want.chunk_index);
            if ({m_tdata[63:61], m_tuser[7:3]} != 8'd0)
                report_mismatch("padding", {m_tdata[63:61], m_tuser[7:3]}, 64'd0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parsed_results.delete();
            rx_phase    = PH_HDR0;
            hdr_fin     = 1'b0;
            hdr_opcode  = OP_CONT;
            hdr_masked  = 1'b0;
            frame_len   = 32'd0;
            len_bytes   = 0;
            mask_word   = 32'd0;
            payload_idx = 32'd0;
            msg_total   = 32'd0;
            chunk_num   = 16'd0;
            chunk_on    = 1'b0;
            halted      = 1'b0;
            len_limit   = MAX_LEN_RESET;
            mismatches  = 0;
            checked     = 0;
            seen        = 8'd0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (cfg_valid && cfg_ready)
                len_limit = cfg_data;
            if (s_tvalid && s_tready)
                parse_rx_byte(s_tdata);
        end
        fail_count      <= mismatches;
        pending_count   <= parsed_results.size();
        results_checked <= checked;
        kinds_seen      <= seen;
    end

endmodule

// ===== test/tb_websocket_frame_deframer.sv =====
// Testbench top for the WebSocket deframer: byte stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;
    import wsd_pkg::*;

    localparam int CHUNK_BYTES  = 256;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;

    typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic [7:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = 32'd0;

    int          fail_count;
    int          pending_count;
    int          results_checked;
    logic [7:0]  kinds_seen;

    int          src_idle = 0;
    int          sink_idle = 0;
    logic        hold_req = 1'b0;
    int          hold_count = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    logic        in_msg = 1'b0;
    logic        big_done = 1'b0;
    logic [31:0] limit_now = MAX_LEN_RESET;
    string       stop_cause = "none";

    websocket_frame_deframer #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    wsd_stream_checker #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .results_checked(results_checked),
        .kinds_seen     (kinds_seen)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout waiting on the deframer");
        $display("Simulation FAILED");
        $finish;
    end

    // hold off the result channel for a long stretch once requested
    always @(posedge clk)
    begin
        if (hold_req && hold_count < HOLD_CYCLES)
        begin
            hold_count <= hold_count + 1;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= sink_idle);
    end

    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_now = value;
    endtask

    task automatic send_frame(input logic fin, input logic [3:0] op, input logic [31:0] len,
                              input len_form_t form, input logic mask_on);
        logic [31:0] key;
        logic [2:0]  rsv;
        key = $urandom;
        rsv = $urandom_range(0, 7);
        frames_sent++;
        send_byte({fin, rsv, op});
        case (form)
            FORM_SHORT: send_byte({mask_on, len[6:0]});
            FORM_EXT16:
            begin
                send_byte({mask_on, LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default:
            begin
                send_byte({mask_on, LEN_EXT64});
                repeat (4) send_byte(8'h00);
                for (int i = 3; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
        endcase
        if (mask_on)
            for (int i = 3; i >= 0; i--)
                send_byte(key[8*i +: 8]);
        for (int unsigned i = 0; i < len; i++)
            send_byte($urandom);
    endtask

    task automatic send_random_frame();
        int          r;
        logic [31:0] len;
        logic [3:0]  op;
        logic        fin;
        logic        force64;
        len_form_t   form;
        force64 = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            op  = $urandom_range(0, 1) ? OP_PING : OP_PONG;
            fin = ($urandom_range(0, 9) != 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 6);
        end
        else
        begin
            // a minority breaks the message sequence on purpose
            if (r < 25)
                op = in_msg ? ($urandom_range(0, 1) ? OP_TEXT : OP_BIN) : OP_CONT;
            else
                op = in_msg ? OP_CONT : ($urandom_range(0, 1) ? OP_TEXT : OP_BIN);
            fin = ($urandom_range(0, 2) != 0);
            if (!big_done && bytes_sent > 150)
            begin
                len      = $urandom_range(CHUNK_BYTES + 1, CHUNK_BYTES + 40);
                big_done = 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(21, 125);
            else
                len = $urandom_range(0, 20);
            if (limit_now <= 125 && $urandom_range(0, 19) == 0)
            begin
                len     = limit_now;
                force64 = 1'b1;
            end
            in_msg = !fin;
        end
        r = $urandom_range(0, 99);
        if (force64 || (len <= limit_now && r >= 80))
            form = FORM_EXT64;
        else if (len <= 125 && r < 55)
            form = FORM_SHORT;
        else
            form = FORM_EXT16;
        send_frame(fin, op, len, form, $urandom_range(0, 3) != 0);
    endtask

    task automatic run_segment(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
            send_random_frame();
    endtask

    task automatic send_stopping_frame();
        logic [3:0]  op;
        logic [31:0] over;
        int          pick;
        case ($urandom_range(0, 3))
            0:
            begin
                stop_cause = "close frame";
                send_frame(1'b1, OP_CLOSE, $urandom_range(0, 4), FORM_SHORT,
                           $urandom_range(0, 1));
            end
            1:
            begin
                stop_cause = "unknown opcode";
                op = $urandom_range(0, 15);
                while (op <= OP_BIN || (op >= OP_CLOSE && op <= OP_PONG))
                    op = $urandom_range(0, 15);
                send_frame($urandom_range(0, 1), op, $urandom_range(0, 4), FORM_SHORT,
                           $urandom_range(0, 1));
            end
            2:
            begin
                stop_cause = "nonzero high length word";
                pick = $urandom_range(0, 3);
                send_byte({1'b1, 3'b000, OP_BIN});
                send_byte({1'($urandom_range(0, 1)), LEN_EXT64});
                for (int i = 0; i < 4; i++)
                    send_byte(i == pick ? 8'($urandom_range(1, 255)) : 8'h00);
            end
            default:
            begin
                stop_cause = "length over limit";
                over = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                   : limit_now + $urandom_range(1, 1000);
                send_byte({1'b1, 3'b000, OP_TEXT});
                send_byte({1'($urandom_range(0, 1)), LEN_EXT64});
                repeat (4) send_byte(8'h00);
                for (int i = 3; i >= 0; i--)
                    send_byte(over[8*i +: 8]);
            end
        endcase
        // drop everything after the stop
        repeat (8) send_byte($urandom);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle = 10;
        sink_idle <= 49;

        send_byte({1'b1, 3'b000, OP_TEXT});
        send_byte({1'b0, 7'd0});
        send_byte({1'b1, 3'b000, OP_PING});
        send_byte({1'b1, 7'd0});
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte({1'b1, 3'b111, OP_PONG});
        send_byte({1'b0, 7'd1});
        send_byte(8'hFF);
        send_byte({1'b0, 3'b000, OP_BIN});
        send_byte({1'b1, 7'd2});
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte({1'b1, 3'b000, OP_CONT});
        send_byte({1'b0, LEN_EXT16});
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h80);
        frames_sent += 5;

        run_segment(50);
        write_limit($urandom_range(1, 40));
        run_segment(50);

        src_idle = 49;
        sink_idle <= 10;
        write_limit(32'd0);
        run_segment(50);
        write_limit(32'hFFFF_FFFF);
        run_segment(50);

        src_idle = 0;
        sink_idle <= 0;
        hold_req <= 1'b1;
        run_segment(50);
        write_limit($urandom_range(1, 300));
        run_segment(25);
        send_stopping_frame();

        wait_drained();
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes in %0d frames; %0d results checked, kinds seen %b.",
                 bytes_sent, frames_sent, results_checked, kinds_seen[6:0]);
        $display("Limits used: reset value, small, zero, all ones; run stopped by %s.",
                 stop_cause);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/wsd_pkg.sv
design/wsd_front.sv
design/wsd_queue.sv
design/wsd_back.sv
design/websocket_frame_deframer.sv
test/wsd_stream_checker.sv
test/tb_websocket_frame_deframer.sv
